// File: design/att_pkg.sv
// Shared types and constants for the allocation tracking table.
`default_nettype none
package att_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_BITS   = 48;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [47:0] ADDR_MASK =
    (ADDR_BITS >= 48) ? 48'hFFFF_FFFF_FFFF : 48'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NULL      = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  localparam logic [8:0] SLOTS_RESET   = 9'd256;
  localparam logic       REG_SLOTS_SEL = 1'b0;

  typedef struct packed {
    logic        func;
    logic [47:0] address;
    logic [31:0] block_size;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [31:0] entry_id;
    logic [31:0] freed_size;
    logic [47:0] active_bytes_now;
    logic [47:0] peak_bytes_now;
    logic [31:0] allocs_so_far;
  } result_t;

  // Search wave handed from cell to cell. Size and id carry the request
  // values on the way in and the freed slot's values once a free has hit.
  typedef struct packed {
    logic              live;
    logic              func;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [47:0]       address;
    logic [31:0]       size;
    logic [31:0]       id;
  } carry_t;

endpackage
`default_nettype wire

// File: design/allocation_tracking_table.sv
// Top level of the allocation tracking table: command port, register port and cell chain.
//
//   Channel   Signals                                  Transfer
//   request   start, busy, request                     taken when start is high and busy low
//   result    done, result                             shown for one cycle, cannot be held off
//   config    psel, penable, pwrite, paddr, pwdata,    APB write on access cycle, pready
//             prdata, pready                           always high
//
// An item with a non-zero address launches a search wave into a chain of
// TABLE_DEPTH cells, moving one cell per cycle; its result strobe follows once
// the wave has left the last cell and the finishing step has run. An item with a
// zero address skips the chain and goes to the finishing step. One item is
// handled at a time and busy stays high until its result is on the ports; the
// next item can be accepted in the cycle the result is shown. Reset clears all
// slot valid flags, the byte totals and the allocation count at once, so no
// clearing pass is needed. The receiver cannot stall results.
`default_nettype none
module allocation_tracking_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  att_pkg::request_t request,
  output logic              done,
  output att_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import att_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t      state;
  logic [8:0]  slots_enabled;
  logic [47:0] outstanding;
  logic [47:0] peak;
  logic [31:0] alloc_total;

  // Result fields settled when the wave leaves the chain or a null address is rejected, sent in ST_FINISH.
  logic [1:0]  pend_status;
  logic [7:0]  pend_slot;
  logic [31:0] pend_id;
  logic [31:0] pend_freed;

  // Launch register feeding cell 0. Element 0 of the chain is the launch
  // register and element k, for k above zero, is the output of cell k-1.
  carry_t launch;
  carry_t carry [TABLE_DEPTH+1];
  carry_t tail;

  logic        accept;
  logic [47:0] addr_eff;
  logic [48:0] add_sum;
  logic [47:0] add_sat;
  logic [47:0] sub_sat;
  logic [47:0] peak_next;
  logic        cfg_write;

  assign accept   = start && !busy;
  assign busy     = (state != ST_IDLE);
  assign addr_eff = request.address & ADDR_MASK;
  assign carry[0] = launch;
  assign tail     = carry[TABLE_DEPTH];

  // Saturating updates of the outstanding byte count.
  assign add_sum   = {1'b0, outstanding} + 49'(tail.size);
  assign add_sat   = add_sum[48] ? BYTES_MAX : add_sum[47:0];
  assign sub_sat   = (outstanding > 48'(tail.size)) ? (outstanding - 48'(tail.size)) : '0;
  assign peak_next = (outstanding > peak) ? outstanding : peak;

  // The register port decodes the word address only.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SLOTS_SEL);
  assign prdata    = (paddr[2] == REG_SLOTS_SEL) ? {23'd0, slots_enabled} : 32'd0;

  // The chain of slot cells. A cell beyond the enabled count keeps its
  // contents but ignores the wave.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic cell_en;
    assign cell_en = (32'(i) < 32'(slots_enabled));
    att_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .enable    (cell_en),
      .index     (SLOT_W'(i)),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      slots_enabled <= SLOTS_RESET;
      outstanding   <= '0;
      peak          <= '0;
      alloc_total   <= '0;
      launch        <= '0;
    end else begin
      done          <= 1'b0;
      launch.live   <= 1'b0;
      if (cfg_write) begin
        slots_enabled <= pwdata[8:0];
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (addr_eff == '0) begin
              // A null address is rejected without touching the table.
              pend_status <= STATUS_NULL;
              pend_slot   <= '0;
              pend_id     <= '0;
              pend_freed  <= '0;
              state       <= ST_FINISH;
            end else begin
              launch.live    <= 1'b1;
              launch.func    <= request.func;
              launch.found   <= 1'b0;
              launch.slot    <= '0;
              launch.address <= addr_eff;
              launch.size    <= request.block_size;
              launch.id      <= alloc_total + 32'd1;
              state          <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (tail.live) begin
            if (tail.found) begin
              pend_status <= STATUS_OK;
              pend_slot   <= 8'(tail.slot);
              pend_id     <= tail.id;
              if (tail.func == FUNC_ALLOC) begin
                pend_freed  <= '0;
                alloc_total <= alloc_total + 32'd1;
                outstanding <= add_sat;
              end else begin
                pend_freed  <= tail.size;
                outstanding <= sub_sat;
              end
            end else begin
              pend_status <= (tail.func == FUNC_ALLOC) ? STATUS_FULL : STATUS_NOT_FOUND;
              pend_slot   <= '0;
              pend_id     <= '0;
              pend_freed  <= '0;
            end
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // The peak only ever rises after an allocation, so taking the
          // larger value here matches an update right after the addition.
          peak                    <= peak_next;
          result.status           <= pend_status;
          result.slot             <= pend_slot;
          result.entry_id         <= pend_id;
          result.freed_size       <= pend_freed;
          result.active_bytes_now <= outstanding;
          result.peak_bytes_now   <= peak_next;
          result.allocs_so_far    <= alloc_total;
          done                    <= 1'b1;
          state                   <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result strobe only follows the finishing step.
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("result strobe without a finishing step");

  // A rejected item reports no slot, id or freed size.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != STATUS_OK)) |->
      ((result.slot == '0) && (result.entry_id == '0) && (result.freed_size == '0)))
    else $error("rejected item carries slot data");

  // The wave only leaves the chain while a search is outstanding.
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.live |-> (state == ST_SCAN))
    else $error("search wave left the chain outside a scan");

  // The byte total never passes the recorded peak once it is reported.
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.active_bytes_now <= result.peak_bytes_now))
    else $error("active bytes above peak");

endmodule
`default_nettype wire

// File: design/att_cell.sv
// One table slot: holds an entry and checks the passing search wave against it.
`default_nettype none
module att_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     enable,
  input  logic [att_pkg::SLOT_W-1:0] index,
  input  att_pkg::carry_t          carry_in,
  output att_pkg::carry_t          carry_out
);
  import att_pkg::*;

  logic        valid;
  logic [47:0] addr;
  logic [31:0] size;
  logic [31:0] id;
  logic        hit;
  carry_t      carry_next;

  always_comb begin
    hit = carry_in.live && !carry_in.found && enable &&
          ((carry_in.func == FUNC_ALLOC) ? !valid
                                         : (valid && (addr == carry_in.address)));
    carry_next = carry_in;
    if (hit) begin
      carry_next.found = 1'b1;
      carry_next.slot  = index;
      if (carry_in.func == FUNC_FREE) begin
        carry_next.size = size;
        carry_next.id   = id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
      if (hit) begin
        valid <= (carry_in.func == FUNC_ALLOC);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && (carry_in.func == FUNC_ALLOC)) begin
      addr <= carry_in.address;
      size <= carry_in.size;
      id   <= carry_in.id;
    end
  end

endmodule
`default_nettype wire
